[rtl/modular_inverse_defines.svh]
// assertion macros for the modular inverse block
// no dependencies
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH
// property that holds every cycle outside reset
`define MI_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");
// implication that must hold in the cycle after the antecedent
`define MI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("check failed");
`endif

[rtl/modinv_pkg.sv]
// shared types for the modular inverse block
// no dependencies
package modinv_pkg;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture operands
    logic div_start; // begin a remainder division
    logic div_step;  // one bit of restoring division
    logic update;    // advance euclid rows
    logic fin;       // final correction
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic trivial;   // modulus zero or one
    logic r1_zero;   // euclid loop finished
    logic div_last;  // last division bit
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_UPD  = 6'b000100,
    S_TEST = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

[rtl/modinv_ctrl.sv]
// controller state machine for the modular inverse block
// depends on modinv_pkg
module modinv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               out_free,
  input  modinv_pkg::stat_t  stat,
  output modinv_pkg::cmd_t   cmd,
  output logic               busy,
  output logic               done
);

  modinv_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= modinv_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    done = 1'b0;
    case (state)
      modinv_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = modinv_pkg::S_TEST;
        end
      end
      modinv_pkg::S_TEST: begin
        if (stat.trivial || stat.r1_zero) state_next = modinv_pkg::S_FIN;
        else begin
          cmd.div_start = 1'b1;
          state_next = modinv_pkg::S_DIV;
        end
      end
      modinv_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = modinv_pkg::S_UPD;
      end
      modinv_pkg::S_UPD: begin
        cmd.update = 1'b1;
        state_next = modinv_pkg::S_TEST;
      end
      modinv_pkg::S_FIN: begin
        cmd.fin = 1'b1;
        state_next = modinv_pkg::S_OUT;
      end
      modinv_pkg::S_OUT: begin
        if (out_free) begin
          done = 1'b1;
          state_next = modinv_pkg::S_IDLE;
        end
      end
      default: state_next = modinv_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != modinv_pkg::S_IDLE);

endmodule

[rtl/modinv_dp.sv]
// euclid datapath: remainder rows, coefficient rows, bit-serial divider
// depends on modinv_pkg
module modinv_dp #(
  parameter int W = 63
) (
  input  logic               clk,
  input  modinv_pkg::cmd_t   cmd,
  input  logic [W-1:0]       m_in,
  input  logic [W-1:0]       v_in,
  output modinv_pkg::stat_t  stat,
  output logic [W-1:0]       inv,
  output logic               ok
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  m, r0, r1, a0, a1, prod, rem, dvd;
  logic          n0, n1;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;
  logic [W-1:0]  inv_next;

  // restoring division: shift in one dividend bit per cycle
  assign trial = {rem, dvd[W-1]} - {1'b0, r1};

  always_comb begin
    inv_next = a0;
    if (n0 && a0 != '0) inv_next = m - a0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m <= m_in; r0 <= m_in; r1 <= v_in;
      a0 <= '0; a1 <= {{(W-1){1'b0}}, 1'b1};
      n0 <= 1'b0; n1 <= 1'b0;
    end
    if (cmd.div_start) begin
      rem <= '0; prod <= '0; dvd <= r0;
      cnt <= CW'(W - 1);
    end
    if (cmd.div_step) begin
      dvd <= dvd << 1;
      cnt <= cnt - CW'(1);
      // quotient bits arrive msb first, so quotient times a1 builds up by horner
      if (!trial[W]) begin
        rem  <= trial[W-1:0];
        prod <= {prod[W-2:0], 1'b0} + a1;
      end else begin
        rem  <= {rem[W-2:0], dvd[W-1]};
        prod <= {prod[W-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      // magnitudes stay at or below the modulus
      r0 <= r1; r1 <= rem;
      a0 <= a1; a1 <= a0 + prod;
      n0 <= n1; n1 <= ~n1;
    end
    if (cmd.fin) begin
      if (m == '0) begin
        inv <= '0; ok <= 1'b0;
      end else if (m == {{(W-1){1'b0}}, 1'b1}) begin
        inv <= '0; ok <= 1'b1;
      end else if (r0 != {{(W-1){1'b0}}, 1'b1}) begin
        inv <= '0; ok <= 1'b0;
      end else begin
        inv <= inv_next; ok <= 1'b1;
      end
    end
  end

  assign stat.trivial  = (m[W-1:1] == '0);
  assign stat.r1_zero  = (r1 == '0);
  assign stat.div_last = (cnt == '0);

endmodule

[rtl/modular_inverse.sv]
// top level of the modular inverse block
// depends on modinv_pkg, modinv_ctrl, modinv_dp, modular_inverse_defines.svh
//
// usage:
//   modulus is written through cfg_we / cfg_data while the block is idle
//   (reset value 2); s_tvalid/s_tready/s_tdata carry the value to invert,
//   m_tvalid/m_tready/m_tdata return inverse and the invertible flag
// each euclid step is a bit-serial remainder division followed by a row
//   update; the loop runs until the remainder row reaches zero, or is skipped for a modulus of zero or one
// only one word is in the block at a time
// the result sits in an output register until m_tready; a new word is
//   taken only once that result is delivered
// reset clears the controller and output valid, modulus returns to 2
`include "modular_inverse_defines.svh"
module modular_inverse #(
  parameter int WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [WIDTH-2:0]   cfg_data,     // modulus
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [8*((WIDTH+6)/8)-1:0] s_tdata,  // value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [8*((WIDTH+7)/8)-1:0] m_tdata   // inverse, invertible
);

  localparam int W = WIDTH - 1;
  localparam int OB = 8 * ((WIDTH + 7) / 8);

  logic [W-1:0]      modulus;
  logic [W-1:0]      inv;
  logic              ok;
  logic              busy, done, start;
  modinv_pkg::cmd_t  cmd;
  modinv_pkg::stat_t stat;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) modulus <= W'(2);
    else if (cfg_we) modulus <= cfg_data;
  end

  assign s_tready = !busy;
  assign start = s_tvalid && s_tready;

  // controller leaves its output state only when the word is taken
  modinv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .out_free(m_tvalid && m_tready),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  modinv_dp #(.W(W)) u_dp (
    .clk(clk), .cmd(cmd), .m_in(modulus), .v_in(s_tdata[W-1:0]),
    .stat(stat), .inv(inv), .ok(ok)
  );

  // result held until taken; controller waits in its output state
  logic out_pend;
  always_ff @(posedge clk) begin
    if (rst) out_pend <= 1'b0;
    else if (cmd.fin) out_pend <= 1'b1;
    else if (done) out_pend <= 1'b0;
  end

  // busy stays high until the word leaves
  logic hold;
  always_ff @(posedge clk) begin
    if (rst) hold <= 1'b0;
    else if (start) hold <= 1'b1;
    else if (m_tvalid && m_tready) hold <= 1'b0;
  end

  assign m_tvalid = out_pend;
  assign m_tdata  = OB'({ok, inv});

  `MI_ASSERT(no_accept_while_out, !(start && out_pend))
  `MI_ASSERT_NEXT(fin_gives_valid, cmd.fin, m_tvalid)
  `MI_ASSERT(hold_covers_busy, !busy || hold)

endmodule

[dv/modular_inverse_test.sv]
// self-checking testbench for modular_inverse: directed and random values over several moduli
// predicts each word with its own extended euclid model; depends on modular_inverse only
module modular_inverse_test;

  localparam int W = 64;
  localparam int OPW = W - 1;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [OPW-1:0] MAX_OPERAND = '1;

  typedef logic [OPW-1:0] operand_t;

  typedef struct {
    operand_t value;
    operand_t inverse;
    logic     invertible;
  } inverse_result_t;

  // expected inverses in order, plus the modulus that the block currently holds
  class inverse_scoreboard;
    inverse_result_t pending[$];
    operand_t modulus = 2;
    int mismatches = 0;

    // extended euclid with coefficient magnitudes and an alternating sign
    function void euclid_inverse(operand_t m, operand_t v,
                                 output operand_t inv, output logic ok);
      longint unsigned r0, r1, r2, a0, a1, a2, q;
      logic n0, n1, n2;
      r0 = m;
      r1 = v;
      a0 = 0;
      a1 = 1;
      n0 = 0;
      n1 = 0;
      inv = '0;
      ok = 0;
      if (m == 0) return;
      if (m == 1) begin
        ok = 1;
        return;
      end
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        a2 = a0 + q * a1;
        n2 = !n1;
        r0 = r1;
        r1 = r2;
        a0 = a1;
        a1 = a2;
        n0 = n1;
        n1 = n2;
      end
      if (r0 != 1) return;
      a0 = a0 % m;
      if (n0 && a0 != 0) a0 = m - a0;
      inv = a0[OPW-1:0];
      ok = 1;
    endfunction

    function void note_value(operand_t v);
      inverse_result_t e;
      e.value = v;
      euclid_inverse(modulus, v, e.inverse, e.invertible);
      pending.push_back(e);
    endfunction

    function void check_result(operand_t inv, logic ok);
      inverse_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: inverse %0d invertible %0b", inv, ok);
        return;
      end
      e = pending.pop_front();
      if (e.inverse !== inv || e.invertible !== ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("value %0d mod %0d: expected inverse %0d invertible %0b, got %0d %0b",
                   e.value, modulus, e.inverse, e.invertible, inv, ok);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [OPW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // value [62:0]
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;        // inverse [62:0], invertible [63]

  inverse_scoreboard sb = new();

  int send_idle_pct = 0;    // chance in a hundred of a gap before each word
  int recv_stall_pct = 0;   // chance in a hundred of m_tready low in a cycle
  logic hold_output = 0;    // long receiver hold-off
  int quiet_cycles = 0;

  modular_inverse #(.WIDTH(W)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: ready changes on the falling edge, results taken on the rising edge
  always @(negedge clk)
    m_tready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[OPW-1:0], m_tdata[OPW]);
  end

  // watchdog counts cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("modular_inverse_test: FAIL");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  function automatic operand_t random_operand();
    return operand_t'({$urandom, $urandom});
  endfunction

  // only called once the block is idle
  task automatic write_modulus(operand_t m);
    @(negedge clk);
    cfg_we = 1;
    cfg_data = m;
    @(negedge clk);
    cfg_we = 0;
    sb.modulus = m;
  endtask

  task automatic send_value(operand_t v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {1'b0, v};
    do @(posedge clk); while (!s_tready);
    sb.note_value(v);
    @(negedge clk);
    s_tvalid = 0;
  endtask

  // wait for every result, then let the block settle so it is truly idle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  initial begin
    operand_t m, v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset modulus two, then the extreme and trivial moduli and a small prime
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(3);
    send_value(MAX_OPERAND);
    drain();
    write_modulus(MAX_OPERAND);
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(MAX_OPERAND);           // same as the modulus, gcd not one
    send_value(MAX_OPERAND - 1);
    send_value(49);                    // shares factor seven with 2^63-1
    drain();
    write_modulus(0);                  // no inverse exists at all
    send_value(0);
    send_value(5);
    drain();
    write_modulus(1);                  // everything invertible, inverse zero
    send_value(0);
    send_value(7);
    drain();
    write_modulus(97);
    send_value(0);
    send_value(97);
    send_value(96);
    send_value(MAX_OPERAND);           // larger than the modulus; the first step swaps the two
    send_value(194);
    drain();

    // random phases, cycling through the idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      set_idling(phase);
      case (phase % 3)
        0: m = random_operand();
        1: m = $urandom_range(1000, 2);
        default: m = random_operand() | 1;
      endcase
      write_modulus(m);
      if (phase == 1) begin
        // receiver holds off while words keep coming, so the block stalls its input
        fork
          begin
            hold_output = 1;
            repeat (3000) @(posedge clk);
            hold_output = 0;
          end
        join_none
      end
      for (int i = 0; i < 14; i++) begin
        case ($urandom_range(3))
          0: v = m * $urandom_range(4);                   // multiples, wrapped at the operand width for large moduli
          1: v = (m > 4) ? m - $urandom_range(3) : random_operand();
          default: v = random_operand();
        endcase
        send_value(v);
      end
      drain();
    end

    set_idling(0);
    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("modular_inverse_test: PASS");
    else
      $display("modular_inverse_test: FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modinv_ctrl.sv
rtl/modinv_dp.sv
rtl/modular_inverse.sv
dv/modular_inverse_test.sv
